FILE: hw/rtl/mtbb_pkg.sv
package mtbb_pkg;

    // Field and register widths
    localparam int VAL_W     = 32;
    localparam int TIME_W    = 32;
    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL   = 1'd1;

    // Register reset values (10.0 and 1.0 in Q16.16)
    localparam logic [VAL_W-1:0] ACCEL_RST = 32'd655360;
    localparam logic [VAL_W-1:0] VEL_RST   = 32'd65536;

    // Internal widths of the axis datapath
    localparam int X_W    = 68;   // radicand 2*W
    localparam int ROOT_W = 35;   // integer square root of the radicand
    localparam int NUM_W  = 70;   // three-segment numerator
    localparam int DEN_W  = 65;   // divisor, up to 2*A*V
    localparam int SV_W   = 34;   // sum of end speeds after the direction flip

    // Pipeline depths
    localparam int FRONT_STAGES = 6;
    localparam int SQ_STAGES    = ROOT_W;
    localparam int DIV_STAGES   = TIME_W;
    localparam int AX_LAT       = FRONT_STAGES + SQ_STAGES + 2 + DIV_STAGES + 1;

    // Sideband that rides alongside the square root
    typedef struct packed {
        logic                    twoseg;
        logic                    tz;
        logic                    rest;
        logic signed [SV_W-1:0]  sv;
        logic [NUM_W-1:0]        num;
    } mtbb_sq_side_t;

    // Result flags that ride alongside the divider
    typedef struct packed {
        logic zero;
        logic sat;
    } mtbb_flags_t;

    // Magnitude of a 33-bit signed value
    function automatic logic [32:0] mag33(input logic signed [32:0] x);
        logic [32:0] r;
        r = x[32] ? 33'(-x) : 33'(x);
        return r;
    endfunction

endpackage

FILE: hw/rtl/mtbb_in_if.sv
interface mtbb_in_if;
    import mtbb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] start_pos_x;
    logic signed [VAL_W-1:0] start_pos_y;
    logic signed [VAL_W-1:0] start_pos_z;
    logic signed [VAL_W-1:0] end_pos_x;
    logic signed [VAL_W-1:0] end_pos_y;
    logic signed [VAL_W-1:0] end_pos_z;
    logic signed [VAL_W-1:0] start_vel_x;
    logic signed [VAL_W-1:0] start_vel_y;
    logic signed [VAL_W-1:0] start_vel_z;
    logic signed [VAL_W-1:0] end_vel_x;
    logic signed [VAL_W-1:0] end_vel_y;
    logic signed [VAL_W-1:0] end_vel_z;

    modport source (
        output valid, start_pos_x, start_pos_y, start_pos_z, end_pos_x, end_pos_y,
               end_pos_z, start_vel_x, start_vel_y, start_vel_z, end_vel_x,
               end_vel_y, end_vel_z,
        input  ready
    );

    modport sink (
        input  valid, start_pos_x, start_pos_y, start_pos_z, end_pos_x, end_pos_y,
               end_pos_z, start_vel_x, start_vel_y, start_vel_z, end_vel_x,
               end_vel_y, end_vel_z,
        output ready
    );

endinterface

FILE: hw/rtl/mtbb_out_if.sv
interface mtbb_out_if;
    import mtbb_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] min_time;

    modport source (
        output valid, min_time,
        input  ready
    );

    modport sink (
        input  valid, min_time,
        output ready
    );

endinterface

FILE: hw/rtl/mtbb_sqrt.sv
module mtbb_sqrt (
    input  logic                    clk,
    input  logic                    en,
    input  logic [mtbb_pkg::X_W-1:0] x,
    input  mtbb_pkg::mtbb_sq_side_t side_in,
    output logic [mtbb_pkg::ROOT_W-1:0] root,
    output mtbb_pkg::mtbb_sq_side_t side_out
);
    import mtbb_pkg::*;

    logic [X_W-1:0]    rem_reg  [1:SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [1:SQ_STAGES];
    mtbb_sq_side_t     side_reg [1:SQ_STAGES];

    // One root bit per stage, most significant first
    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
        localparam int B = SQ_STAGES - 1 - s;

        logic [X_W-1:0]    rem_cur;
        logic [ROOT_W-1:0] root_cur;
        mtbb_sq_side_t     side_cur;
        logic [X_W+3:0]    delta;
        logic              take;
        logic [X_W-1:0]    rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0) begin : g_first
            assign rem_cur  = x;
            assign root_cur = '0;
            assign side_cur = side_in;
        end
        else begin : g_rest
            assign rem_cur  = rem_reg[s];
            assign root_cur = root_reg[s];
            assign side_cur = side_reg[s];
        end

        // Try setting bit B: (r + 2^B)^2 - r^2 = 4^B + r * 2^(B+1)
        always_comb
        begin
            delta     = ((X_W+4)'(1) << (2 * B)) + ((X_W+4)'(root_cur) << (B + 1));
            take      = {4'b0, rem_cur} >= delta;
            rem_next  = take ? rem_cur - delta[X_W-1:0] : rem_cur;
            root_next = take ? (root_cur | (ROOT_W'(1) << B)) : root_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_next;
                root_reg[s+1] <= root_next;
                side_reg[s+1] <= side_cur;
            end
        end
    end

    assign root     = root_reg[SQ_STAGES];
    assign side_out = side_reg[SQ_STAGES];

endmodule

FILE: hw/rtl/mtbb_div.sv
module mtbb_div #(
    parameter int NW = 97
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [NW-1:0]                 n,
    input  logic [mtbb_pkg::DEN_W-1:0]    dn,
    input  mtbb_pkg::mtbb_flags_t         fl_in,
    output logic [mtbb_pkg::TIME_W-1:0]   q,
    output mtbb_pkg::mtbb_flags_t         fl_out
);
    import mtbb_pkg::*;

    logic [NW-1:0]     n_reg  [1:DIV_STAGES];
    logic [DEN_W-1:0]  dn_reg [1:DIV_STAGES];
    logic [TIME_W-1:0] q_reg  [1:DIV_STAGES];
    mtbb_flags_t       fl_reg [1:DIV_STAGES];

    // Restoring division, one quotient bit per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
        localparam int B = DIV_STAGES - 1 - s;

        logic [NW-1:0]     n_cur;
        logic [DEN_W-1:0]  dn_cur;
        logic [TIME_W-1:0] q_cur;
        mtbb_flags_t       fl_cur;
        logic [NW-1:0]     trial;
        logic              take;
        logic [NW-1:0]     n_next;
        logic [TIME_W-1:0] q_next;

        if (s == 0) begin : g_first
            assign n_cur  = n;
            assign dn_cur = dn;
            assign q_cur  = '0;
            assign fl_cur = fl_in;
        end
        else begin : g_rest
            assign n_cur  = n_reg[s];
            assign dn_cur = dn_reg[s];
            assign q_cur  = q_reg[s];
            assign fl_cur = fl_reg[s];
        end

        always_comb
        begin
            trial  = NW'(dn_cur) << B;
            take   = n_cur >= trial;
            n_next = take ? n_cur - trial : n_cur;
            q_next = take ? (q_cur | (TIME_W'(1) << B)) : q_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1]  <= n_next;
                dn_reg[s+1] <= dn_cur;
                q_reg[s+1]  <= q_next;
                fl_reg[s+1] <= fl_cur;
            end
        end
    end

    assign q      = q_reg[DIV_STAGES];
    assign fl_out = fl_reg[DIV_STAGES];

endmodule

FILE: hw/rtl/mtbb_axis.sv
module mtbb_axis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [mtbb_pkg::VAL_W-1:0]          acc,
    input  logic [mtbb_pkg::VAL_W-1:0]          vel,
    input  logic [mtbb_pkg::DEN_W-1:0]          lim,
    input  logic [mtbb_pkg::DEN_W-1:0]          acc2vel,
    input  logic signed [mtbb_pkg::VAL_W-1:0]   p1,
    input  logic signed [mtbb_pkg::VAL_W-1:0]   p2,
    input  logic signed [mtbb_pkg::VAL_W-1:0]   v1,
    input  logic signed [mtbb_pkg::VAL_W-1:0]   v2,
    output logic [mtbb_pkg::TIME_W-1:0]         tm
);
    import mtbb_pkg::*;

    localparam int NW = (NUM_W + FRAC_BITS > DEN_W + TIME_W) ?
                        NUM_W + FRAC_BITS : DEN_W + TIME_W;

    // ---- stage A: differences ----
    logic signed [32:0] a_d_next, a_dv_next, a_sv_next;
    logic signed [32:0] a_d_reg, a_dv_reg, a_sv_reg;
    logic signed [VAL_W-1:0] a_v1_reg, a_v2_reg;
    logic a_rest_reg;

    always_comb
    begin
        a_d_next  = $signed({p2[VAL_W-1], p2}) - $signed({p1[VAL_W-1], p1});
        a_dv_next = $signed({v2[VAL_W-1], v2}) - $signed({v1[VAL_W-1], v1});
        a_sv_next = $signed({v2[VAL_W-1], v2}) + $signed({v1[VAL_W-1], v1});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_d_reg    <= a_d_next;
            a_dv_reg   <= a_dv_next;
            a_sv_reg   <= a_sv_next;
            a_v1_reg   <= v1;
            a_v2_reg   <= v2;
            a_rest_reg <= (a_d_next == '0) && (a_dv_next == '0);
        end
    end

    // ---- stage B: products ----
    logic [64:0] b_ad_reg;
    logic [65:0] b_svdv_reg;
    logic [63:0] b_v1sq_reg, b_v2sq_reg;
    logic signed [32:0] b_d_reg, b_sv_reg;
    logic signed [VAL_W-1:0] b_v1_reg, b_v2_reg;
    logic b_rest_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ad_reg   <= 65'(acc) * 65'(mag33(a_d_reg));
            b_svdv_reg <= 66'(mag33(a_sv_reg)) * 66'(mag33(a_dv_reg));
            b_v1sq_reg <= 64'(mag33(33'(a_v1_reg))) * 64'(mag33(33'(a_v1_reg)));
            b_v2sq_reg <= 64'(mag33(33'(a_v2_reg))) * 64'(mag33(33'(a_v2_reg)));
            b_d_reg    <= a_d_reg;
            b_sv_reg   <= a_sv_reg;
            b_v1_reg   <= a_v1_reg;
            b_v2_reg   <= a_v2_reg;
            b_rest_reg <= a_rest_reg;
        end
    end

    // ---- stage C: pick the direction of the first phase ----
    logic [65:0] c_ad2_next;
    logic        c_na, c_nb, c_ge, c_flip;
    logic [65:0] c_ad2_reg;
    logic [64:0] c_sq_reg;
    logic        c_dneg_reg, c_rest_reg;
    logic signed [32:0] c_v1_reg, c_v2_reg;
    logic signed [SV_W-1:0] c_sv_reg;

    always_comb
    begin
        c_ad2_next = {b_ad_reg, 1'b0};
        c_na   = b_d_reg[32] && (b_ad_reg != '0);
        c_nb   = b_sv_reg[32] && (b_svdv_reg != '0);
        c_ge   = (c_na != c_nb) ? c_nb :
                 (c_na ? (c_ad2_next <= b_svdv_reg) : (c_ad2_next >= b_svdv_reg));
        c_flip = !c_ge;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ad2_reg  <= c_ad2_next;
            c_sq_reg   <= 65'(b_v1sq_reg) + 65'(b_v2sq_reg);
            c_dneg_reg <= c_flip ? (b_d_reg > 33'sd0) : b_d_reg[32];
            c_v1_reg   <= c_flip ? -33'(b_v1_reg) : 33'(b_v1_reg);
            c_v2_reg   <= c_flip ? -33'(b_v2_reg) : 33'(b_v2_reg);
            c_sv_reg   <= c_flip ? -SV_W'(b_sv_reg) : SV_W'(b_sv_reg);
            c_rest_reg <= b_rest_reg;
        end
    end

    // ---- stage D: discriminant and cruise speed gaps ----
    logic signed [34:0] d_dif1, d_dif2, d_abs1, d_abs2;
    logic [66:0] d_w_reg;
    logic        d_wneg_reg, d_dneg_reg, d_rest_reg;
    logic [33:0] d_e1_reg, d_e2_reg;
    logic [65:0] d_ad2_reg;
    logic signed [SV_W-1:0] d_sv_reg;

    always_comb
    begin
        d_dif1 = $signed({3'b0, vel}) - 35'(c_v1_reg);
        d_dif2 = $signed({3'b0, vel}) - 35'(c_v2_reg);
        d_abs1 = d_dif1[34] ? -d_dif1 : d_dif1;
        d_abs2 = d_dif2[34] ? -d_dif2 : d_dif2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_w_reg    <= c_dneg_reg ? 67'({1'b0, c_sq_reg} - c_ad2_reg)
                                     : 67'(c_sq_reg) + 67'(c_ad2_reg);
            d_wneg_reg <= c_dneg_reg && ({1'b0, c_sq_reg} < c_ad2_reg);
            d_e1_reg   <= d_abs1[33:0];
            d_e2_reg   <= d_abs2[33:0];
            d_ad2_reg  <= c_ad2_reg;
            d_dneg_reg <= c_dneg_reg;
            d_sv_reg   <= c_sv_reg;
            d_rest_reg <= c_rest_reg;
        end
    end

    // ---- stage E: squares of the gaps, pick two or three segments ----
    logic [67:0] e_e1sq_reg, e_e2sq_reg;
    logic [66:0] e_w_reg;
    logic [65:0] e_ad2_reg;
    logic        e_twoseg_reg, e_dneg_reg, e_rest_reg;
    logic signed [SV_W-1:0] e_sv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_e1sq_reg   <= 68'(d_e1_reg) * 68'(d_e1_reg);
            e_e2sq_reg   <= 68'(d_e2_reg) * 68'(d_e2_reg);
            e_twoseg_reg <= !d_wneg_reg && (d_w_reg <= 67'(lim));
            e_w_reg      <= d_w_reg;
            e_ad2_reg    <= d_ad2_reg;
            e_dneg_reg   <= d_dneg_reg;
            e_sv_reg     <= d_sv_reg;
            e_rest_reg   <= d_rest_reg;
        end
    end

    // ---- stage F: three-segment numerator, radicand ----
    logic [NUM_W-1:0] f_sum;
    mtbb_sq_side_t    f_side_next, f_side_reg;
    logic [X_W-1:0]   f_x_reg;

    always_comb
    begin
        f_sum              = NUM_W'(e_e1sq_reg) + NUM_W'(e_e2sq_reg);
        f_side_next.twoseg = e_twoseg_reg;
        f_side_next.tz     = e_dneg_reg && (f_sum <= NUM_W'(e_ad2_reg));
        f_side_next.rest   = e_rest_reg;
        f_side_next.sv     = e_sv_reg;
        f_side_next.num    = e_dneg_reg ? f_sum - NUM_W'(e_ad2_reg)
                                        : f_sum + NUM_W'(e_ad2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_x_reg    <= {e_w_reg, 1'b0};
            f_side_reg <= f_side_next;
        end
    end

    // ---- square root ----
    logic [ROOT_W-1:0] s_root;
    mtbb_sq_side_t     s_side;

    mtbb_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .x        (f_x_reg),
        .side_in  (f_side_reg),
        .root     (s_root),
        .side_out (s_side)
    );

    // ---- stage G: choose dividend and divisor ----
    logic signed [36:0] g_n;
    logic [NW-1:0]      g_n_reg;
    logic [DEN_W-1:0]   g_dn_reg;
    logic               g_zero_reg;

    assign g_n = $signed({2'b0, s_root}) - 37'(s_side.sv);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_zero_reg <= s_side.rest ||
                          (s_side.twoseg ? (g_n <= 37'sd0) : s_side.tz);
            g_n_reg    <= s_side.twoseg ? (NW'(g_n[35:0]) << FRAC_BITS)
                                        : (NW'(s_side.num) << FRAC_BITS);
            g_dn_reg   <= s_side.twoseg ? DEN_W'(acc) : acc2vel;
        end
    end

    // ---- stage H: saturation check ----
    logic [NW-1:0]    h_n_reg;
    logic [DEN_W-1:0] h_dn_reg;
    mtbb_flags_t      h_fl_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_n_reg       <= g_n_reg;
            h_dn_reg      <= g_dn_reg;
            h_fl_reg.zero <= g_zero_reg;
            h_fl_reg.sat  <= g_n_reg >= (NW'(g_dn_reg) << TIME_W);
        end
    end

    // ---- division ----
    logic [TIME_W-1:0] q_q;
    mtbb_flags_t       q_fl;

    mtbb_div #(.NW(NW)) u_div (
        .clk    (clk),
        .en     (en),
        .n      (h_n_reg),
        .dn     (h_dn_reg),
        .fl_in  (h_fl_reg),
        .q      (q_q),
        .fl_out (q_fl)
    );

    // ---- stage I: apply zero and saturation ----
    logic [TIME_W-1:0] tm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm_reg <= q_fl.zero ? '0 : (q_fl.sat ? '1 : q_q);
        end
    end

    assign tm = tm_reg;

endmodule

FILE: hw/rtl/min_time_bang_bang_distance.sv
// Minimum-time distance between two point-mass states over three axes.
//
// Channels: query (sink) takes one word per item: start and end positions and
// velocities of axes x, y and z, signed Q16.16. result (source) returns one
// word per item: min_time, the largest per-axis bang-bang time, unsigned
// Q16.16, clamped at 0 and at all ones. Both channels move a word on a
// rising edge with valid and ready high.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0: accel
// bound, 1: velocity bound); a bound of 0 acts as one LSB. Write only while
// the block is idle.
// Path: an accepted word passes through the per-axis pipeline (35 square-root
// stages, 32 divider stages), then the largest-axis pick and the result register.
// Throughput: one word per cycle while no result word waits.
// Reset: the pipeline empties, result.valid drops and both bounds return to
// 10.0 and 1.0.
// Stall: while a result word waits, the whole pipeline holds and query.ready
// is low; nothing is dropped or repeated.
module min_time_bang_bang_distance #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mtbb_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [mtbb_pkg::VAL_W-1:0]        cfg_wdata,
    mtbb_in_if.sink                           query,
    mtbb_out_if.source                        result
);
    import mtbb_pkg::*;

    // ---- configuration ----
    logic [VAL_W-1:0] acc_reg, vel_reg;
    logic [VAL_W-1:0] acc_eff, vel_eff;
    logic [VAL_W-1:0] acc_eff_reg, vel_eff_reg;
    logic [DEN_W-1:0] lim_reg, acc2vel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= ACCEL_RST;
            vel_reg <= VEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ACCEL: acc_reg <= cfg_wdata;
                REG_VEL:   vel_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Treat a zero bound as one LSB
    assign acc_eff = (acc_reg == '0) ? VAL_W'(1) : acc_reg;
    assign vel_eff = (vel_reg == '0) ? VAL_W'(1) : vel_reg;

    // Derive the bound products once per cycle
    always_ff @(posedge clk)
    begin
        acc_eff_reg <= acc_eff;
        vel_eff_reg <= vel_eff;
        lim_reg     <= (DEN_W'(vel_eff) * DEN_W'(vel_eff)) << 1;
        acc2vel_reg <= (DEN_W'(acc_eff) * DEN_W'(vel_eff)) << 1;
    end

    // ---- flow control ----
    logic              adv;
    logic [AX_LAT-1:0] vld_reg;
    logic              out_valid_reg;
    logic [TIME_W-1:0] out_reg;

    assign adv         = !out_valid_reg || result.ready;
    assign query.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[AX_LAT-2:0], query.valid};
            out_valid_reg <= vld_reg[AX_LAT-1];
        end
    end

    // ---- axis lanes ----
    logic signed [VAL_W-1:0] sp [AXES];
    logic signed [VAL_W-1:0] ep [AXES];
    logic signed [VAL_W-1:0] sv [AXES];
    logic signed [VAL_W-1:0] ev [AXES];
    logic [TIME_W-1:0]       tm [AXES];

    assign sp[0] = query.start_pos_x;
    assign sp[1] = query.start_pos_y;
    assign sp[2] = query.start_pos_z;
    assign ep[0] = query.end_pos_x;
    assign ep[1] = query.end_pos_y;
    assign ep[2] = query.end_pos_z;
    assign sv[0] = query.start_vel_x;
    assign sv[1] = query.start_vel_y;
    assign sv[2] = query.start_vel_z;
    assign ev[0] = query.end_vel_x;
    assign ev[1] = query.end_vel_y;
    assign ev[2] = query.end_vel_z;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        mtbb_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
            .clk     (clk),
            .en      (adv),
            .acc     (acc_eff_reg),
            .vel     (vel_eff_reg),
            .lim     (lim_reg),
            .acc2vel (acc2vel_reg),
            .p1      (sp[a]),
            .p2      (ep[a]),
            .v1      (sv[a]),
            .v2      (ev[a]),
            .tm      (tm[a])
        );
    end

    // ---- largest axis time ----
    logic [TIME_W-1:0] best;

    always_comb
    begin
        best = '0;
        for (int i = 0; i < AXES; i++)
        begin
            if (tm[i] > best)
            begin
                best = tm[i];
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= best;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.min_time = out_reg;

endmodule
